[hw/rtl/hera_pkg.sv]
`default_nettype none
package hera_pkg;
  localparam int unsigned WordW = 31;
  localparam int unsigned IdxW = 4;
  localparam int unsigned NumWords = 16;

  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdMixCol = 2'd1,
    CmdMixRow = 2'd2,
    CmdCube = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [IdxW-1:0] idx;
    logic [WordW-1:0] value;
  } hera_item_t;
endpackage
`default_nettype wire

[hw/rtl/hera_round_layers_mod_p.sv]
`default_nettype none
// Load: from transfer to state update, the steps are dequeue, launch and a serial
// reduction; the back end takes no new command until that reduction is done.
// Mix: one reduction and one result per word, in word order over all 16 words.
// Cube: two reductions per word, then one result per word.
// busy is high while the two-entry command queue is full. Results are strobed one
// cycle each; the receiver cannot stall. Reset zeroes state, modulus 65537.
module hera_round_layers_mod_p (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  word_index_i,
  input  wire logic [30:0] word_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] cfg_data_i,
  output logic             out_strobe_o,
  output logic [3:0]       out_index_o,
  output logic [30:0]      out_value_o,
  output logic             out_last_o
);
  import hera_pkg::*;

  logic [WordW-1:0] mod_q;
  logic full, avail, pop, idle;
  hera_item_t it, head;

  assign it = '{cmd: command_i, idx: word_index_i, value: word_value_i};
  assign busy = full;
  // modulus only changes once queue and back end have drained
  assign cfg_ready_o = idle && !avail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= 31'd65537;
    else if (cfg_valid_i && cfg_ready_o) mod_q <= cfg_data_i;
  end

  hera_front u_front (.clk_i, .rst_ni, .push_i(start && !full), .item_i(it),
    .full_o(full), .pop_i(pop), .avail_o(avail), .head_o(head));

  hera_back u_back (.clk_i, .rst_ni, .avail_i(avail), .item_i(head), .pop_o(pop),
    .idle_o(idle), .p_i(mod_q), .strobe_o(out_strobe_o), .out_index_o,
    .out_value_o, .out_last_o);
endmodule
`default_nettype wire

[hw/rtl/hera_modred.sv]
`default_nettype none
// Sequential reduction: x mod p by restoring shift-subtract, one bit per cycle.
module hera_modred (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [61:0]              x_i,
  input  wire logic [hera_pkg::WordW-1:0] p_i,
  output logic                          done_o,
  output logic [hera_pkg::WordW-1:0]    r_o
);
  import hera_pkg::*;

  logic [61:0] x_q, x_d;
  logic [WordW:0] rem_q, rem_d;
  logic [5:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic [WordW+1:0] sh;

  always_comb begin
    x_d = x_q; rem_d = rem_q; cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    sh = {rem_q, x_q[61]};
    if (start_i) begin
      x_d = x_i; rem_d = '0; cnt_d = 6'd62; run_d = 1'b1;
    end else if (run_q) begin
      x_d = {x_q[60:0], 1'b0};
      if (sh >= {2'b00, p_i}) rem_d = (WordW+1)'(sh - {2'b00, p_i});
      else rem_d = sh[WordW:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign r_o = (p_i < 31'd2) ? '0 : rem_q[WordW-1:0];
endmodule
`default_nettype wire

[hw/rtl/hera_front.sv]
`default_nettype none
// Command front end: two-entry queue of accepted commands.
module hera_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire hera_pkg::hera_item_t item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      avail_o,
  output hera_pkg::hera_item_t      head_o
);
  import hera_pkg::*;

  hera_item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  assign full_o = cnt_q[1];
  assign avail_o = cnt_q != 2'd0;
  assign head_o = mem_q[rp_q];
endmodule
`default_nettype wire

[hw/rtl/hera_back.sv]
`default_nettype none
// Executes one command: per word, reduces the loaded value or a linear/square/cube term.
module hera_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     avail_i,
  input  wire hera_pkg::hera_item_t     item_i,
  output logic                          pop_o,
  output logic                          idle_o,
  input  wire logic [hera_pkg::WordW-1:0] p_i,
  output logic                          strobe_o,
  output logic [hera_pkg::IdxW-1:0]     out_index_o,
  output logic [hera_pkg::WordW-1:0]    out_value_o,
  output logic                          out_last_o
);
  import hera_pkg::*;

  typedef enum logic [5:0] {
    SIdle = 6'b000001, SLoad = 6'b000010, SCalc = 6'b000100,
    SRed1 = 6'b001000, SCub = 6'b010000, SRed2 = 6'b100000
  } st_e;

  st_e st_q, st_d;
  logic [WordW-1:0] ws_q [NumWords];
  logic [WordW-1:0] nw_q [NumWords];
  logic [1:0] cmd_q;
  logic [IdxW-1:0] idx_q;
  logic [WordW-1:0] val_q;
  logic [WordW-1:0] sq_q;
  logic rs;
  logic [61:0] rx;
  logic rd;
  logic [WordW-1:0] rr;
  logic [IdxW-1:0] b, s;
  logic [1:0] k;
  logic [WordW-1:0] a0, a1, a2, a3;
  logic [33:0] lin;
  logic strobe_q;
  logic [IdxW-1:0] oi_q;
  logic [WordW-1:0] ov_q;

  hera_modred u_red (.clk_i, .rst_ni, .start_i(rs), .x_i(rx), .p_i, .done_o(rd), .r_o(rr));

  // group base/stride for word idx_q
  always_comb begin
    if (cmd_q == CmdMixCol) begin
      b = {idx_q[3:2], 2'b00}; s = 4'd1; k = idx_q[1:0];
    end else begin
      b = {2'b00, idx_q[1:0]}; s = 4'd4; k = idx_q[3:2];
    end
    a0 = ws_q[b]; a1 = ws_q[4'(b + s)];
    a2 = ws_q[4'(b + 4'(2 * s))]; a3 = ws_q[4'(b + 4'(3 * s))];
    case (k)
      2'd0: lin = 34'({a0, 1'b0}) + 34'(a1) * 34'd3 + 34'(a2) + 34'(a3);
      2'd1: lin = 34'(a0) + 34'({a1, 1'b0}) + 34'(a2) * 34'd3 + 34'(a3);
      2'd2: lin = 34'(a0) + 34'(a1) + 34'({a2, 1'b0}) + 34'(a3) * 34'd3;
      default: lin = 34'(a0) * 34'd3 + 34'(a1) + 34'(a2) + 34'({a3, 1'b0});
    endcase
  end

  always_comb begin
    st_d = st_q; rs = 1'b0; rx = '0; pop_o = 1'b0;
    case (st_q)
      SIdle: if (avail_i) begin
        pop_o = 1'b1;
        st_d = (item_i.cmd == CmdLoad) ? SLoad : SCalc;
      end
      SLoad: begin
        rs = 1'b1; rx = 62'(val_q); st_d = SRed2;
      end
      SCalc: begin
        rs = 1'b1;
        if (cmd_q == CmdCube) begin
          rx = 62'(ws_q[idx_q]) * 62'(ws_q[idx_q]); st_d = SRed1;
        end else begin
          rx = 62'(lin); st_d = SRed2;
        end
      end
      SRed1: if (rd) st_d = SCub;
      SCub: begin
        rs = 1'b1; rx = 62'(sq_q) * 62'(ws_q[idx_q]); st_d = SRed2;
      end
      SRed2: if (rd) begin
        if (cmd_q == CmdLoad || idx_q == 4'd15) st_d = SIdle;
        else st_d = SCalc;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; strobe_q <= 1'b0;
      for (int i = 0; i < NumWords; i++) ws_q[i] <= '0;
    end else begin
      st_q <= st_d;
      strobe_q <= 1'b0;
      if (st_q == SRed2 && rd) begin
        if (cmd_q == CmdLoad) ws_q[idx_q] <= rr;
        else begin
          strobe_q <= 1'b1;
          if (idx_q == 4'd15)
            for (int i = 0; i < NumWords - 1; i++) ws_q[i] <= nw_q[i];
          if (idx_q == 4'd15) ws_q[15] <= rr;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && avail_i) begin
      cmd_q <= item_i.cmd;
      idx_q <= (item_i.cmd == CmdLoad) ? item_i.idx : '0;
      val_q <= item_i.value;
    end
    if (st_q == SRed1 && rd) sq_q <= rr;
    if (st_q == SRed2 && rd && cmd_q != CmdLoad) begin
      nw_q[idx_q] <= rr;
      oi_q <= idx_q; ov_q <= rr;
      idx_q <= idx_q + 4'd1;
    end
  end

  assign idle_o = (st_q == SIdle);
  assign strobe_o = strobe_q;
  assign out_index_o = oi_q;
  assign out_value_o = ov_q;
  assign out_last_o = strobe_q && (oi_q == 4'd15);
endmodule
`default_nettype wire
